// ----- rtl/thpac_pkg.sv -----
// ----------------------------------------------------------------------------
// thpac_pkg
// Shared types and register indexes for the thruster pulse attitude controller.
// ----------------------------------------------------------------------------
package thpac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RATE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK_WINDOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK_RATE_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WINDOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_RATE_WINDOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_LEVEL       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL    = 3'd7;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 56;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] control_value;
        logic               settled;
    } cmd_t;

    typedef struct packed {
        logic              we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

// ----- rtl/thruster_pulse_attitude_control_top.sv -----
// an accepted beat passes the multiply stage register, the command queue and the output register before m_tvalid
// throughput: one beat per cycle while s_tready is high, limited by the single-cycle window select loop in the front
// a four-entry command queue lets front and back stall independently
// reset (async, rst_n low): registers to their default values, wide windows, valves closed,
// open time zero, queue and output empty
// ----------------------------------------------------------------------------
// thruster_pulse_attitude_control_top
// Roll-axis thruster pulse controller: deadzone, PD control and valve timing.
// ----------------------------------------------------------------------------
module thruster_pulse_attitude_control_top #(
    parameter int unsigned BUDGET_MS    = 30000,
    parameter int unsigned PULSE_MAX_MS = 100,
    parameter int unsigned COOLDOWN_MS  = 100
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [thpac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [thpac_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0], target_angle[47:32], roll_angle[63:48], rate_x[79:64], rate_z[95:80]
    input  logic [thpac_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // valve_cw_on[0], valve_ccw_on[1], control_value[17:2], settled[18],
    // used_ms[50:19], budget_spent[51], zero[55:52]
    output logic [thpac_pkg::M_TDATA_W-1:0]     m_tdata
);

    thpac_pkg::cfg_wr_t            cfg;
    thpac_pkg::cmd_t               push_data;
    thpac_pkg::cmd_t               pop_data;
    logic                          push;
    logic                          pop;
    logic                          q_empty;
    logic [thpac_pkg::QCNT_W-1:0]  q_count;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    thpac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    thpac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .count     (q_count)
    );

    thpac_back #(
        .BUDGET_MS    (BUDGET_MS),
        .PULSE_MAX_MS (PULSE_MAX_MS),
        .COOLDOWN_MS  (COOLDOWN_MS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/thpac_front.sv -----
// ----------------------------------------------------------------------------
// thpac_front
// Accepts beats, applies the deadzone test and computes the saturated control.
// ----------------------------------------------------------------------------
module thpac_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  thpac_pkg::cfg_wr_t                cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [thpac_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [thpac_pkg::QCNT_W-1:0]      q_count,
    output logic                              push,
    output thpac_pkg::cmd_t                   push_data
);

    logic signed [15:0] gain_prop_reg;
    logic signed [15:0] gain_rate_reg;
    logic [14:0]        seek_window_reg;
    logic [14:0]        seek_rate_window_reg;
    logic [14:0]        hold_window_reg;
    logic [14:0]        hold_rate_window_reg;
    logic               wide_window_reg;

    logic               s1_valid_reg;
    logic [31:0]        s1_now_reg;
    logic               s1_settled_reg;
    logic signed [32:0] s1_prod_p_reg;
    logic signed [31:0] s1_prod_r_reg;

    logic               accept;
    logic [31:0]        now_ms;
    logic signed [15:0] target_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_z;
    logic signed [16:0] err;
    logic [16:0]        err_abs;
    logic signed [16:0] rx_ext;
    logic [16:0]        rx_abs;
    logic [14:0]        win;
    logic [14:0]        rwin;
    logic               in_zone;
    logic signed [32:0] prod_p_next;
    logic signed [31:0] prod_r_next;
    logic signed [34:0] sum;
    logic signed [22:0] quot;
    logic signed [15:0] sat;
    logic [thpac_pkg::QCNT_W-1:0] pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg        <= 16'sd2458;
            gain_rate_reg        <= 16'sd1638;
            seek_window_reg      <= 15'd1638;
            seek_rate_window_reg <= 15'd410;
            hold_window_reg      <= 15'd2458;
            hold_rate_window_reg <= 15'd4096;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                thpac_pkg::CFG_GAIN_PROP:        gain_prop_reg        <= cfg.data;
                thpac_pkg::CFG_GAIN_RATE:        gain_rate_reg        <= cfg.data;
                thpac_pkg::CFG_SEEK_WINDOW:      seek_window_reg      <= cfg.data[14:0];
                thpac_pkg::CFG_SEEK_RATE_WINDOW: seek_rate_window_reg <= cfg.data[14:0];
                thpac_pkg::CFG_HOLD_WINDOW:      hold_window_reg      <= cfg.data[14:0];
                thpac_pkg::CFG_HOLD_RATE_WINDOW: hold_rate_window_reg <= cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // credit check: queue entries plus the beat in the multiply stage
    assign pending  = q_count + {{(thpac_pkg::QCNT_W-1){1'b0}}, s1_valid_reg};
    assign s_tready = pending < thpac_pkg::QCNT_W'(thpac_pkg::QDEPTH);
    assign accept   = s_tvalid && s_tready;

    assign now_ms       = s_tdata[31:0];
    assign target_angle = s_tdata[47:32];
    assign roll_angle   = s_tdata[63:48];
    assign rate_x       = s_tdata[79:64];
    assign rate_z       = s_tdata[95:80];

    always_comb
    begin
        err     = 17'(target_angle) - 17'(roll_angle);
        err_abs = err[16] ? 17'(-err) : 17'(err);
        rx_ext  = 17'(rate_x);
        rx_abs  = rx_ext[16] ? 17'(-rx_ext) : 17'(rx_ext);
        win     = wide_window_reg ? hold_window_reg : seek_window_reg;
        rwin    = wide_window_reg ? hold_rate_window_reg : seek_rate_window_reg;
        in_zone = (err_abs < {2'b00, win}) && (rx_abs < {2'b00, rwin});
        prod_p_next = 33'(gain_prop_reg) * 33'(err);
        prod_r_next = 32'(gain_rate_reg) * 32'(rate_z);
    end

    // the window choice only matters while the budget lasts; once spent the back
    // holds for good, so the front may keep updating it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_window_reg <= 1'b1;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                wide_window_reg <= in_zone;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_now_reg     <= now_ms;
            s1_settled_reg <= in_zone;
            s1_prod_p_reg  <= prod_p_next;
            s1_prod_r_reg  <= prod_r_next;
        end
    end

    // round to nearest, ties up, then saturate to 16 bits
    always_comb
    begin
        sum  = 35'(s1_prod_p_reg) + 35'(s1_prod_r_reg) + 35'sd2048;
        quot = sum[34:12];
        if (quot > 23'sd32767)
        begin
            sat = 16'sh7fff;
        end
        else if (quot < -23'sd32768)
        begin
            sat = 16'sh8000;
        end
        else
        begin
            sat = quot[15:0];
        end
    end

    assign push                    = s1_valid_reg;
    assign push_data.now_ms        = s1_now_reg;
    assign push_data.settled       = s1_settled_reg;
    assign push_data.control_value = s1_settled_reg ? 16'sd0 : sat;

endmodule

// ----- rtl/thpac_queue.sv -----
// ----------------------------------------------------------------------------
// thpac_queue
// Short command queue between the control front and the valve back.
// ----------------------------------------------------------------------------
module thpac_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  thpac_pkg::cmd_t               push_data,
    input  logic                          pop,
    output thpac_pkg::cmd_t               pop_data,
    output logic                          empty,
    output logic [thpac_pkg::QCNT_W-1:0]  count
);

    thpac_pkg::cmd_t                 mem_reg [thpac_pkg::QDEPTH];
    logic [thpac_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [thpac_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [thpac_pkg::QCNT_W-1:0]    count_reg;
    logic [thpac_pkg::QCNT_W-1:0]    count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = count_reg == '0;
    assign count    = count_reg;

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < thpac_pkg::QCNT_W'(thpac_pkg::QDEPTH)))
        else $error("queue push while full");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_ptr_count : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[thpac_pkg::QPTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ----- rtl/thpac_back.sv -----
// ----------------------------------------------------------------------------
// thpac_back
// Valve drive: thresholds, pulse limit, cooldown and open time bookkeeping.
// ----------------------------------------------------------------------------
module thpac_back #(
    parameter int unsigned BUDGET_MS    = 30000,
    parameter int unsigned PULSE_MAX_MS = 100,
    parameter int unsigned COOLDOWN_MS  = 100
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  thpac_pkg::cfg_wr_t                cfg,
    input  logic                              q_empty,
    input  thpac_pkg::cmd_t                   q_data,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [thpac_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam logic [31:0] BUDGET    = 32'(BUDGET_MS);
    localparam logic [31:0] PULSE_LIM = 32'(PULSE_MAX_MS);
    localparam logic [31:0] COOL      = 32'(COOLDOWN_MS);

    logic [14:0] fire_level_reg;
    logic [14:0] release_level_reg;
    logic        cw_open_reg;
    logic        ccw_open_reg;
    logic [31:0] pulse_start_reg;
    logic [31:0] cooldown_until_reg;
    logic [31:0] open_total_reg;
    logic        m_valid_reg;
    logic [thpac_pkg::M_TDATA_W-1:0] m_data_reg;

    logic        cw_open_next;
    logic        ccw_open_next;
    logic [31:0] pulse_start_next;
    logic [31:0] cooldown_until_next;
    logic [31:0] open_total_next;
    logic [thpac_pkg::M_TDATA_W-1:0] m_data_next;

    logic               spent;
    logic               cooling;
    logic signed [16:0] c_ext;
    logic [16:0]        c_abs;
    logic signed [16:0] rel_pos;
    logic signed [16:0] rel_neg;
    logic               fire;
    logic               cw1;
    logic               ccw1;
    logic               rel_cw;
    logic               rel_ccw;
    logic               cw2;
    logic               ccw2;
    logic [31:0]        elapsed;
    logic               limit_hit;
    logic               closing;
    logic [32:0]        total_sum;
    logic signed [15:0] ctrl_out;
    logic               settled_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fire_level_reg    <= 15'd410;
            release_level_reg <= 15'd410;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                thpac_pkg::CFG_FIRE_LEVEL:    fire_level_reg    <= cfg.data[14:0];
                thpac_pkg::CFG_RELEASE_LEVEL: release_level_reg <= cfg.data[14:0];
                default: ;
            endcase
        end
    end

    assign pop = !q_empty && (!m_valid_reg || m_tready);

    always_comb
    begin
        spent   = open_total_reg > BUDGET;
        cooling = q_data.now_ms < cooldown_until_reg;
        c_ext   = 17'(q_data.control_value);
        c_abs   = c_ext[16] ? 17'(-c_ext) : 17'(c_ext);
        rel_pos = $signed({2'b00, release_level_reg});
        rel_neg = -rel_pos;

        fire = (c_abs > {2'b00, fire_level_reg}) && !cw_open_reg && !ccw_open_reg;
        cw1  = cw_open_reg || (fire && (c_ext > 17'sd0));
        ccw1 = ccw_open_reg || (fire && !(c_ext > 17'sd0));
        pulse_start_next = fire ? q_data.now_ms : pulse_start_reg;

        rel_cw  = cw1 && (c_ext < rel_pos);
        rel_ccw = ccw1 && (c_ext > rel_neg);
        cw2     = cw1 && !rel_cw;
        ccw2    = ccw1 && !rel_ccw;

        // at most one valve is ever open, so one close per step at most
        elapsed   = q_data.now_ms - pulse_start_next;
        limit_hit = (cw2 || ccw2) && (elapsed > PULSE_LIM);
        closing   = rel_cw || rel_ccw || limit_hit;
        total_sum = {1'b0, open_total_reg} + {1'b0, elapsed};

        cw_open_next        = cw2 && !limit_hit;
        ccw_open_next       = ccw2 && !limit_hit;
        cooldown_until_next = limit_hit ? (q_data.now_ms + COOL) : cooldown_until_reg;
        open_total_next     = open_total_reg;
        if (closing)
        begin
            open_total_next = total_sum[32] ? 32'hffff_ffff : total_sum[31:0];
        end

        if (spent)
        begin
            cw_open_next        = cw_open_reg;
            ccw_open_next       = ccw_open_reg;
            pulse_start_next    = pulse_start_reg;
            cooldown_until_next = cooldown_until_reg;
            open_total_next     = open_total_reg;
        end
        else if (cooling)
        begin
            cw_open_next        = 1'b0;
            ccw_open_next       = 1'b0;
            pulse_start_next    = pulse_start_reg;
            cooldown_until_next = cooldown_until_reg;
            open_total_next     = open_total_reg;
        end

        ctrl_out    = spent ? 16'sd0 : q_data.control_value;
        settled_out = spent ? 1'b0 : q_data.settled;
        m_data_next = {4'b0000,
                       open_total_next > BUDGET,
                       open_total_next,
                       settled_out,
                       ctrl_out,
                       ccw_open_next,
                       cw_open_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_open_reg        <= 1'b0;
            ccw_open_reg       <= 1'b0;
            pulse_start_reg    <= '0;
            cooldown_until_reg <= '0;
            open_total_reg     <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cw_open_reg        <= cw_open_next;
                ccw_open_reg       <= ccw_open_next;
                pulse_start_reg    <= pulse_start_next;
                cooldown_until_reg <= cooldown_until_next;
                open_total_reg     <= open_total_next;
                m_valid_reg        <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_one_valve : assert property (@(posedge clk) disable iff (!rst_n)
        !(cw_open_reg && ccw_open_reg))
        else $error("both valves open");

    a_total_grows : assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> open_total_reg >= $past(open_total_reg))
        else $error("open time went down");

    a_spent_holds : assert property (@(posedge clk) disable iff (!rst_n)
        spent |=> (open_total_reg == $past(open_total_reg))
                  && (cw_open_reg == $past(cw_open_reg)))
        else $error("state moved after budget spent");

endmodule

// ----- sim/tb_thruster_pulse_attitude_control_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thruster_pulse_attitude_control_top
// Self-checking bench for the roll-axis thruster pulse controller. A short table
// of sensor beats and register writes comes first, then random phases under
// default, extreme, unity-gain and random register settings, then a closing run
// that uses up the valve-time budget. Each result beat is compared with its table
// value or with a cycle-free model of the deadzone, the PD law and the valve timing.
// ----------------------------------------------------------------------------
module tb_thruster_pulse_attitude_control_top;

    localparam int unsigned BUDGET_MS    = 30000;
    localparam int unsigned PULSE_MAX_MS = 100;
    localparam int unsigned COOLDOWN_MS  = 100;
    localparam int NUM_REGS    = 1 << thpac_pkg::CFG_IDX_W;
    localparam int PHASE_ITEMS = 60;

    localparam logic [thpac_pkg::CFG_DATA_W-1:0] REG_RESET [NUM_REGS] =
        '{16'd2458, 16'd1638, 16'd1638, 16'd410, 16'd2458, 16'd4096, 16'd410, 16'd410};

    typedef struct packed {
        logic signed [15:0] rate_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] roll;
        logic signed [15:0] target;
        logic [31:0]        now;
    } sensor_beat_t;

    typedef struct packed {
        logic [3:0]         pad;
        logic               spent;
        logic [31:0]        used;
        logic               settled;
        logic signed [15:0] ctrl;
        logic               ccw;
        logic               cw;
    } valve_result_t;

    typedef struct {
        bit                               is_reg;
        logic [thpac_pkg::CFG_IDX_W-1:0]  idx;
        logic [thpac_pkg::CFG_DATA_W-1:0] val;
        sensor_beat_t                     beat;
        bit                               typed;
        valve_result_t                    want;
    } dir_row_t;

    typedef enum {SET_DEFAULTS, SET_HIGH, SET_LOW, SET_UNITY, SET_RANDOM} setting_t;
    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_SPARSE} ready_mode_t;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [thpac_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [thpac_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [thpac_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [thpac_pkg::M_TDATA_W-1:0]  m_tdata;

    // model state
    logic [thpac_pkg::CFG_DATA_W-1:0] reg_val [NUM_REGS] = REG_RESET;
    bit                    pred_wide = 1'b1;
    bit                    pred_cw   = 1'b0;
    bit                    pred_ccw  = 1'b0;
    logic [31:0]           pulse_t0  = '0;
    logic [31:0]           cool_end  = '0;
    logic [31:0]           open_sum  = '0;

    valve_result_t valve_results_due [$];
    int            fail_count = 0;
    logic [31:0]   clock_ms   = '0;
    int            burst_left = 0;
    int            gap_left   = 0;
    ready_mode_t   ready_mode = RDY_ALWAYS;
    int            ready_span = 0;

    thruster_pulse_attitude_control_top #(
        .BUDGET_MS    (BUDGET_MS),
        .PULSE_MAX_MS (PULSE_MAX_MS),
        .COOLDOWN_MS  (COOLDOWN_MS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void add_open_time(input logic [31:0] now);
        logic [31:0] d;
        logic [32:0] s;
        d = now - pulse_t0;
        s = {1'b0, open_sum} + {1'b0, d};
        open_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void drive_valves(input int c, input logic [31:0] now);
        int          fire_lv;
        int          rel_lv;
        logic [31:0] elapsed;
        fire_lv = reg_val[thpac_pkg::CFG_FIRE_LEVEL][14:0];
        rel_lv  = reg_val[thpac_pkg::CFG_RELEASE_LEVEL][14:0];
        if (now < cool_end)
        begin
            pred_cw  = 1'b0;
            pred_ccw = 1'b0;
            return;
        end
        if (mag(c) > fire_lv && !pred_cw && !pred_ccw)
        begin
            if (c > 0)
                pred_cw = 1'b1;
            else
                pred_ccw = 1'b1;
            pulse_t0 = now;
        end
        if (pred_cw && c < rel_lv)
        begin
            pred_cw = 1'b0;
            add_open_time(now);
        end
        if (pred_ccw && c > -rel_lv)
        begin
            pred_ccw = 1'b0;
            add_open_time(now);
        end
        elapsed = now - pulse_t0;
        if ((pred_cw || pred_ccw) && elapsed > PULSE_MAX_MS)
        begin
            pred_cw  = 1'b0;
            pred_ccw = 1'b0;
            add_open_time(now);
            cool_end = now + COOLDOWN_MS;
        end
    endfunction

    function automatic valve_result_t predict_valves(input sensor_beat_t b);
        valve_result_t r;
        int            err;
        int            ang_win;
        int            rate_win;
        int            ctrl;
        longint        acc;
        bit            in_zone;
        ctrl    = 0;
        in_zone = 1'b0;
        // once the budget is used up nothing moves
        if (open_sum <= BUDGET_MS)
        begin
            err      = int'(b.target) - int'(b.roll);
            ang_win  = pred_wide ? reg_val[thpac_pkg::CFG_HOLD_WINDOW][14:0]
                                 : reg_val[thpac_pkg::CFG_SEEK_WINDOW][14:0];
            rate_win = pred_wide ? reg_val[thpac_pkg::CFG_HOLD_RATE_WINDOW][14:0]
                                 : reg_val[thpac_pkg::CFG_SEEK_RATE_WINDOW][14:0];
            in_zone  = (mag(err) < ang_win) && (mag(int'(b.rate_x)) < rate_win);
            pred_wide = in_zone;
            if (!in_zone)
            begin
                acc = longint'($signed(reg_val[thpac_pkg::CFG_GAIN_PROP])) * err
                    + longint'($signed(reg_val[thpac_pkg::CFG_GAIN_RATE])) * int'(b.rate_z);
                // round half up, then clamp to 16 bits
                acc = (acc + 2048) >>> 12;
                if (acc > 32767)
                    acc = 32767;
                else if (acc < -32768)
                    acc = -32768;
                ctrl = int'(acc);
            end
            drive_valves(ctrl, b.now);
        end
        r.pad     = '0;
        r.cw      = pred_cw;
        r.ccw     = pred_ccw;
        r.ctrl    = 16'(ctrl);
        r.settled = in_zone;
        r.used    = open_sum;
        r.spent   = (open_sum > BUDGET_MS);
        return r;
    endfunction

    function automatic sensor_beat_t beat_of(input logic [31:0] now, input int tgt,
                                             input int roll, input int rx, input int rz);
        sensor_beat_t b;
        b.now    = now;
        b.target = 16'(tgt);
        b.roll   = 16'(roll);
        b.rate_x = 16'(rx);
        b.rate_z = 16'(rz);
        return b;
    endfunction

    function automatic dir_row_t item_row(input logic [31:0] now, input int tgt,
                                          input int roll, input int rx, input int rz);
        dir_row_t r;
        r.is_reg = 1'b0;
        r.idx    = '0;
        r.val    = '0;
        r.beat   = beat_of(now, tgt, roll, rx, rz);
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input logic [thpac_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [thpac_pkg::CFG_DATA_W-1:0] val);
        dir_row_t r;
        r        = item_row(32'd0, 0, 0, 0, 0);
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic dir_row_t with_result(input dir_row_t r, input bit cw, input bit ccw,
                                             input int ctrl, input bit settled,
                                             input logic [31:0] used, input bit spent);
        r.typed        = 1'b1;
        r.want.pad     = '0;
        r.want.cw      = cw;
        r.want.ccw     = ccw;
        r.want.ctrl    = 16'(ctrl);
        r.want.settled = settled;
        r.want.used    = used;
        r.want.spent   = spent;
        return r;
    endfunction

    function automatic logic [thpac_pkg::CFG_DATA_W-1:0] phase_reg(input setting_t kind,
                                                                   input int idx);
        logic [thpac_pkg::CFG_DATA_W-1:0] v;
        bit                               is_gain;
        bit                               is_level;
        is_gain  = (idx <= thpac_pkg::CFG_GAIN_RATE);
        is_level = (idx >= thpac_pkg::CFG_FIRE_LEVEL);
        case (kind)
            SET_DEFAULTS: v = REG_RESET[idx];
            // top bit of a window write must be dropped
            SET_HIGH:     v = is_gain ? 16'h7FFF : (is_level ? 16'h0000 : 16'hFFFF);
            SET_LOW:      v = is_gain ? 16'h8000 : (is_level ? 16'h7FFF : 16'h0000);
            SET_UNITY:
            begin
                if (idx == thpac_pkg::CFG_GAIN_PROP)
                    v = 16'd4096;
                else if (idx == thpac_pkg::CFG_GAIN_RATE)
                    v = 16'd0;
                else
                    v = is_level ? 16'($urandom_range(0, 800)) : 16'($urandom_range(0, 3000));
            end
            default:
            begin
                v = 16'($urandom);
                if (!is_gain && $urandom_range(0, 3) != 0)
                    v = {v[15], 3'b000, v[11:0]};
            end
        endcase
        return v;
    endfunction

    function automatic sensor_beat_t random_beat(input bit wild);
        int               sel;
        logic signed [15:0] roll;
        int               tgt;
        int               rx;
        int               rz;
        if (wild)
            clock_ms = $urandom;
        else if (!pred_cw && !pred_ccw && $urandom_range(0, 39) == 0)
            // jump the time base only with both valves shut
            clock_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FF00 + $urandom_range(0, 255);
        else
        begin
            sel = $urandom_range(0, 9);
            if (open_sum > 20000)
                clock_ms += $urandom_range(0, 5);
            else if (sel < 7)
                clock_ms += $urandom_range(0, 40);
            else if (sel < 9)
                clock_ms += $urandom_range(90, 110);
            else
                clock_ms += $urandom_range(111, 300);
        end
        sel  = $urandom_range(0, 9);
        roll = 16'($urandom);
        if (sel == 0)
        begin
            roll = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            tgt  = int'(~roll);
        end
        else if (sel <= 3)
            tgt = int'($urandom);
        else
            tgt = int'(roll) + int'($urandom_range(0, 6000)) - 3000;
        rx = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'($urandom_range(0, 5000)) - 2500;
        rz = $urandom_range(0, 1) ? int'($urandom) : int'($urandom_range(0, 4000)) - 2000;
        return beat_of(clock_ms, tgt, int'(roll), rx, rz);
    endfunction

    task automatic send_beat(input sensor_beat_t b, input bit typed, input valve_result_t want);
        valve_result_t pred;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        while (gap_left > 0)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            gap_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_valves(b);
        valve_results_due.push_back(typed ? want : pred);
        burst_left--;
        @(negedge clk);
    endtask

    // registers only change with nothing in flight
    task automatic write_reg(input logic [thpac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [thpac_pkg::CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (valve_results_due.size() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we       <= 1'b0;
        reg_val[idx] = val;
        @(negedge clk);
    endtask

    task automatic report_field(input string fname, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, e, a);
        end
    endtask

    always @(negedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_span = $urandom_range(20, 150);
        end
        ready_span--;
        case (ready_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RDY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
            default:    m_tready <= (ready_span % 4 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        valve_result_t got;
        valve_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (valve_results_due.size() == 0)
            begin
                fail_count++;
                $display("%0t: result beat with none outstanding, actual %0h", $time, m_tdata);
            end
            else
            begin
                want = valve_results_due.pop_front();
                report_field("valve_cw_on", want.cw, got.cw);
                report_field("valve_ccw_on", want.ccw, got.ccw);
                report_field("control_value", want.ctrl, got.ctrl);
                report_field("settled", want.settled, got.settled);
                report_field("used_ms", want.used, got.used);
                report_field("budget_spent", want.spent, got.spent);
                report_field("padding", want.pad, got.pad);
            end
        end
    end

    initial
    begin
        dir_row_t    rows [$];
        setting_t    plan [8];
        logic [31:0] t_end;
        int          drain;

        plan = '{SET_DEFAULTS, SET_HIGH, SET_LOW, SET_UNITY,
                 SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM};

        rows.push_back(with_result(item_row(32'd0, 0, 0, 0, 0), 0, 0, 0, 1, 32'd0, 0));
        rows.push_back(with_result(item_row(32'd10, 32767, -32768, 0, 0),
                                   1, 0, 32767, 0, 32'd0, 0));
        rows.push_back(with_result(item_row(32'd20, -32768, 32767, 0, 0),
                                   0, 0, -32768, 0, 32'd10, 0));
        // ccw pulse runs into the length limit, then cooldown
        rows.push_back(item_row(32'd30, -32768, 32767, 0, 0));
        rows.push_back(item_row(32'd131, -32768, 32767, 0, 0));
        rows.push_back(item_row(32'd230, -32768, 32767, 0, 0));
        rows.push_back(item_row(32'd231, -32768, 32767, 0, 0));
        rows.push_back(item_row(32'd331, -32768, 32767, 0, 0));
        rows.push_back(item_row(32'd332, -32768, 32767, 0, 0));
        rows.push_back(item_row(32'd400, 0, 0, -32768, 32767));
        rows.push_back(item_row(32'd440, 0, 0, 32767, -32768));
        rows.push_back(item_row(32'd450, 0, 0, 0, 0));
        rows.push_back(reg_row(thpac_pkg::CFG_GAIN_PROP, 16'd4096));
        rows.push_back(reg_row(thpac_pkg::CFG_GAIN_RATE, 16'd0));
        rows.push_back(reg_row(thpac_pkg::CFG_HOLD_WINDOW, 16'd0));
        rows.push_back(reg_row(thpac_pkg::CFG_SEEK_WINDOW, 16'd0));
        // fire and release thresholds exactly at the level
        rows.push_back(item_row(32'd500, 410, 0, 0, 0));
        rows.push_back(item_row(32'd510, 411, 0, 0, 0));
        rows.push_back(item_row(32'd520, 410, 0, 0, 0));
        rows.push_back(item_row(32'd530, 409, 0, 0, 0));
        // half-way rounding goes up
        rows.push_back(reg_row(thpac_pkg::CFG_GAIN_PROP, 16'd2048));
        rows.push_back(item_row(32'd540, 1, 0, 0, 0));
        rows.push_back(item_row(32'd550, -1, 0, 0, 0));
        rows.push_back(item_row(32'd560, -3, 0, 0, 0));
        // pulse across the 32-bit time wrap
        rows.push_back(item_row(32'hFFFF_FFC0, 32767, 0, 0, 0));
        rows.push_back(item_row(32'h0000_0030, 32767, 0, 0, 0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_reg)
                write_reg(rows[i].idx, rows[i].val);
            else
                send_beat(rows[i].beat, rows[i].typed, rows[i].want);
        end

        clock_ms = 32'd1000;
        foreach (plan[p])
        begin
            for (int k = 0; k < NUM_REGS; k++)
                write_reg(thpac_pkg::CFG_IDX_W'(k), phase_reg(plan[p], k));
            repeat (PHASE_ITEMS)
                send_beat(random_beat(1'b0), 1'b0, '0);
        end

        // open a valve, then step time back so the elapsed time saturates the total
        write_reg(thpac_pkg::CFG_GAIN_PROP, 16'd4096);
        write_reg(thpac_pkg::CFG_GAIN_RATE, 16'd0);
        write_reg(thpac_pkg::CFG_HOLD_WINDOW, 16'd0);
        write_reg(thpac_pkg::CFG_SEEK_WINDOW, 16'd0);
        write_reg(thpac_pkg::CFG_FIRE_LEVEL, 16'd10);
        write_reg(thpac_pkg::CFG_RELEASE_LEVEL, 16'd10);
        t_end = (cool_end > 32'h8000_0000) ? cool_end : 32'h8000_0000;
        send_beat(beat_of(t_end, 1000, 0, 0, 0), 1'b0, '0);
        send_beat(beat_of(t_end - 1, 1000, 0, 0, 0), 1'b0, '0);
        repeat (30)
            send_beat(random_beat(1'b1), 1'b0, '0);

        s_tvalid <= 1'b0;
        drain = 0;
        while (valve_results_due.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (valve_results_due.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d result beats never arrived", $time, valve_results_due.size());
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
